FILE: rtl/kwqc_pkg.sv
package kwqc_pkg;

    // Table and field sizes
    localparam int QUERIES    = 256;
    localparam int IDX_W      = $clog2(QUERIES);
    localparam int MAX_K      = 31;
    localparam int KMER_W     = 2 * MAX_K;
    localparam int K_W        = 5;
    localparam int COUNT_BITS = 32;
    localparam int OP_W       = 2;
    localparam int CODE_W     = 4;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = CODE_W + IDX_W + KMER_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = IDX_W + COUNT_BITS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Item kinds
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_NUC  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Base codes
    localparam logic [CODE_W-1:0] CODE_C = 4'd2;
    localparam logic [CODE_W-1:0] CODE_G = 4'd4;
    localparam logic [CODE_W-1:0] CODE_T = 4'd8;
    localparam logic [CODE_W-1:0] CODE_N = 4'd15;

    localparam logic [K_W-1:0] KMER_LEN_RESET = 5'd31;

    // Map a 4-bit base code to its 2-bit base; unknown codes count as A
    function automatic logic [1:0] base_of(input logic [CODE_W-1:0] code);
        logic [1:0] b;
        case (code)
            CODE_C:  b = 2'd1;
            CODE_G:  b = 2'd2;
            CODE_T:  b = 2'd3;
            default: b = 2'd0;
        endcase
        return b;
    endfunction

    // Zero length acts as one base
    function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] k);
        return (k == '0) ? K_W'(1) : k;
    endfunction

    // Low 2*k bits set
    function automatic logic [KMER_W-1:0] kmer_mask(input logic [K_W-1:0] k);
        logic [KMER_W-1:0] m;
        for (int i = 0; i < MAX_K; i++) begin
            m[2*i +: 2] = (i < int'(k)) ? 2'b11 : 2'b00;
        end
        return m;
    endfunction

endpackage

FILE: rtl/kwqc_ram.sv
module kwqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/kmer_window_query_counter_unit.sv
// Rolling k-mer match counter. Items arrive on the s_ stream with the kind in
// s_tuser: load a query entry, feed one base of a read, or read out a counter;
// each item gives exactly one result beat on the m_ stream. The block takes
// one item at a time and drops s_tready while it works. A base that completes
// a window is captured, then passes over all 256 table entries through the
// single read port of the query memory (one entry per cycle, with registered
// read data), reads the hit counter and, on a hit only, writes it back, and
// then posts the result. A base that does not complete a window, an N, or an
// unused kind is captured and posted; a load shifts k bases, k being kmer_len
// with zero counted as one, through the 2-bit-per-cycle reverse-complement
// shifter and then writes the query table; a readout reads the counter and
// posts it. kmer_len must be written on the cfg port only while the block is
// idle, which the block itself does not enforce; there is no clearing pass
// after reset, so the block is ready at once.
module kmer_window_query_counter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // cfg_data: kmer_len[4:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kwqc_pkg::K_W-1:0]            cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: nuc_code[3:0], query_index[11:4], query_kmer[73:12], zero pad
    input  logic [kwqc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: op[1:0]
    input  logic [kwqc_pkg::OP_W-1:0]           s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: hit_index[7:0], count_value[39:8]
    output logic [kwqc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tuser: hit
    output logic                                m_tuser
);

    import kwqc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RC   = 4'd1;
    localparam logic [3:0] S_QWR  = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CWR  = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_RDD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [K_W-1:0]        klen_reg;
    logic [OP_W-1:0]       op_reg, op_next;
    logic                  last_reg, last_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [KMER_W-1:0]     q_reg, q_next;
    logic [KMER_W-1:0]     sh_reg, sh_next;
    logic [KMER_W-1:0]     rc_reg, rc_next;
    logic [K_W-1:0]        step_reg, step_next;
    logic [KMER_W-1:0]     win_reg, win_next;
    logic [K_W-1:0]        fill_reg, fill_next;
    logic [IDX_W:0]        scan_reg, scan_next;
    logic                  rdv_reg, rdv_next;
    logic [IDX_W-1:0]      rdi_reg, rdi_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic                  res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic [COUNT_BITS-1:0] res_cnt_reg, res_cnt_next;
    logic                  mval_reg, mval_next;
    logic                  mhit_reg, mhit_next;
    logic [IDX_W-1:0]      midx_reg, midx_next;
    logic [COUNT_BITS-1:0] mcnt_reg, mcnt_next;
    logic [QUERIES-1:0]    qvalid_reg, qvalid_next;
    logic [QUERIES-1:0]    cvalid_reg, cvalid_next;

    logic [K_W-1:0]        keff;
    logic [KMER_W-1:0]     kmask;
    logic                  accept;
    logic [CODE_W-1:0]     in_code;
    logic [IDX_W-1:0]      in_idx;
    logic [KMER_W-1:0]     in_kmer;
    logic [KMER_W-1:0]     win_shift;
    logic [K_W-1:0]        fill_inc;
    logic                  q_we;
    logic [2*KMER_W-1:0]   q_rdata;
    logic                  match;
    logic                  c_we;
    logic [IDX_W-1:0]      c_raddr;
    logic [COUNT_BITS-1:0] c_rdata;
    logic [COUNT_BITS-1:0] c_old;
    logic [COUNT_BITS-1:0] c_new;

    assign keff    = eff_k(klen_reg);
    assign kmask   = kmer_mask(keff);
    assign in_code = s_tdata[CODE_W-1:0];
    assign in_idx  = s_tdata[CODE_W +: IDX_W];
    assign in_kmer = s_tdata[CODE_W+IDX_W +: KMER_W];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Shift the new base into the window and advance the fill
    assign win_shift = {win_reg[KMER_W-3:0], base_of(in_code)} & kmask;
    assign fill_inc  = (fill_reg < keff) ? fill_reg + K_W'(1) : keff;

    // Query table: reverse complement in the upper half, query in the lower
    kwqc_ram #(
        .WIDTH(2 * KMER_W),
        .DEPTH(QUERIES)
    ) u_qram (
        .clk  (clk),
        .we   (q_we),
        .waddr(idx_reg),
        .wdata({rc_reg, q_reg}),
        .raddr(scan_reg[IDX_W-1:0]),
        .rdata(q_rdata)
    );

    assign q_we  = (state_reg == S_QWR);
    assign match = rdv_reg && qvalid_reg[rdi_reg] &&
                   ((q_rdata[KMER_W-1:0] == win_reg) ||
                    (q_rdata[2*KMER_W-1:KMER_W] == win_reg));

    // Hit counters; an entry never written reads as zero
    kwqc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(QUERIES)
    ) u_cram (
        .clk  (clk),
        .we   (c_we),
        .waddr(best_reg),
        .wdata(c_new),
        .raddr(c_raddr),
        .rdata(c_rdata)
    );

    assign c_raddr = (state_reg == S_RD) ? idx_reg : best_reg;
    assign c_old   = cvalid_reg[best_reg] ? c_rdata : '0;
    assign c_new   = (c_old == {COUNT_BITS{1'b1}}) ? c_old : c_old + COUNT_BITS'(1);
    assign c_we    = (state_reg == S_CWR);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        q_next       = q_reg;
        sh_next      = sh_reg;
        rc_next      = rc_reg;
        step_next    = step_reg;
        win_next     = win_reg;
        fill_next    = fill_reg;
        scan_next    = scan_reg;
        rdv_next     = rdv_reg;
        rdi_next     = rdi_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        res_hit_next = res_hit_reg;
        res_idx_next = res_idx_reg;
        res_cnt_next = res_cnt_reg;
        mval_next    = mval_reg;
        mhit_next    = mhit_reg;
        midx_next    = midx_reg;
        mcnt_next    = mcnt_reg;
        qvalid_next  = qvalid_reg;
        cvalid_next  = cvalid_reg;

        // Drop the output beat once taken
        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = s_tuser;
                    last_next    = s_tlast;
                    idx_next     = in_idx;
                    res_hit_next = 1'b0;
                    res_idx_next = '0;
                    res_cnt_next = '0;
                    state_next   = S_DONE;
                    case (s_tuser)
                        OP_LOAD:
                        begin
                            q_next     = in_kmer & kmask;
                            sh_next    = in_kmer & kmask;
                            rc_next    = '0;
                            step_next  = '0;
                            state_next = S_RC;
                        end
                        OP_NUC:
                        begin
                            if (in_code == CODE_N)
                            begin
                                win_next  = '0;
                                fill_next = '0;
                            end
                            else
                            begin
                                win_next  = win_shift;
                                fill_next = fill_inc;
                                if (fill_inc >= keff)
                                begin
                                    scan_next  = '0;
                                    rdv_next   = 1'b0;
                                    found_next = 1'b0;
                                    best_next  = '0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RC:
            begin
                // Reverse complement, one base per cycle from the low end
                rc_next   = {rc_reg[KMER_W-3:0], ~sh_reg[1:0]};
                sh_next   = sh_reg >> 2;
                step_next = step_reg + K_W'(1);
                if (step_reg == keff - K_W'(1))
                begin
                    state_next = S_QWR;
                end
            end
            S_QWR:
            begin
                qvalid_next[idx_reg] = 1'b1;
                state_next           = S_DONE;
            end
            S_SCAN:
            begin
                // Issue one table read per cycle, compare the one returned
                if (!scan_reg[IDX_W])
                begin
                    scan_next = scan_reg + (IDX_W+1)'(1);
                    rdv_next  = 1'b1;
                    rdi_next  = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    rdv_next   = 1'b0;
                    state_next = S_CRD;
                end
                if (match)
                begin
                    found_next = 1'b1;
                    best_next  = rdi_reg;
                end
            end
            S_CRD:
            begin
                state_next = found_reg ? S_CWR : S_DONE;
            end
            S_CWR:
            begin
                cvalid_next[best_reg] = 1'b1;
                res_hit_next          = 1'b1;
                res_idx_next          = best_reg;
                state_next            = S_DONE;
            end
            S_RD:
            begin
                state_next = S_RDD;
            end
            S_RDD:
            begin
                res_cnt_next = cvalid_reg[idx_reg] ? c_rdata : '0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // Post the result once the output register is free
                if (!mval_reg || m_tready)
                begin
                    mval_next = 1'b1;
                    mhit_next = res_hit_reg;
                    midx_next = res_idx_reg;
                    mcnt_next = res_cnt_reg;
                    if (op_reg == OP_NUC && last_reg)
                    begin
                        win_next  = '0;
                        fill_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            klen_reg   <= KMER_LEN_RESET;
            win_reg    <= '0;
            fill_reg   <= '0;
            mval_reg   <= 1'b0;
            qvalid_reg <= '0;
            cvalid_reg <= '0;
            rdv_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            mval_reg   <= mval_next;
            qvalid_reg <= qvalid_next;
            cvalid_reg <= cvalid_next;
            rdv_reg    <= rdv_next;
            found_reg  <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                klen_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        last_reg    <= last_next;
        idx_reg     <= idx_next;
        q_reg       <= q_next;
        sh_reg      <= sh_next;
        rc_reg      <= rc_next;
        step_reg    <= step_next;
        scan_reg    <= scan_next;
        rdi_reg     <= rdi_next;
        best_reg    <= best_next;
        res_hit_reg <= res_hit_next;
        res_idx_reg <= res_idx_next;
        res_cnt_reg <= res_cnt_next;
        mhit_reg    <= mhit_next;
        midx_reg    <= midx_next;
        mcnt_reg    <= mcnt_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tuser  = mhit_reg;
    assign m_tdata  = OUT_TDATA_W'({mcnt_reg, midx_reg});

endmodule

FILE: rtl/kwqc_checker.sv
module kwqc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [kwqc_pkg::K_W-1:0]            cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [kwqc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [kwqc_pkg::OP_W-1:0]           s_tuser,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [kwqc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tuser
);

    import kwqc_pkg::*;

    // Every item keeps the block busy past the beat that carried it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    // No hit means no index
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[IDX_W-1:0] == '0))
        else $error("hit index set without a hit");

    // A hit beat carries no count
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[IDX_W +: COUNT_BITS] == '0))
        else $error("count value set on a hit beat");

endmodule

bind kmer_window_query_counter_unit kwqc_checker u_kwqc_checker (.*);
